/* sv/lse_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg: shared types, constants and helper functions for the max-star unit
// holds the exp rom generator, the divide-by-five reciprocal and the item
// format passed from the front end through the queue to the back end
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int LUT_ENTRIES_DEF = 256;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int VAL_W  = 24;          // q11.12 operand and result width
  localparam int DIST_W = VAL_W + 1;   // |a-b| never exceeds 2^24-1
  localparam int EXP_W  = 17;          // q1.16, 0..65536

  localparam logic signed [VAL_W:0] VAL_MAX = 25'sd8388607;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  // middle log1p branch starts where 100*e reaches 1.0 in q16
  localparam logic [15:0] SMALL_E_LIMIT = 16'((65536 + 99) / 100);

  // cubic term scaling: floor((333333*c + 500000) / 1000000)
  localparam logic [51:0] TERM_MUL     = 52'd333333;
  localparam logic [51:0] HALF_MILLION = 52'd500000;
  localparam logic [51:0] MILLION      = 52'd1000000;
  localparam longint unsigned THIRD_MUL = (64'd333333 << 32) / 64'd1000000;

  // reciprocal of five, exact for operands below 2^22
  localparam int DIV5_SHIFT = 24;
  localparam logic [21:0] DIV5_MUL = 22'((64'd1 << DIV5_SHIFT) / 5 + 1);

  typedef struct packed {
    logic signed [VAL_W-1:0] mx;    // larger operand
    logic [DIST_W-1:0]       gap;   // absolute difference
  } lse_item_t;

  function automatic logic [19:0] div5(input logic [21:0] x);
    logic [43:0] p;
    p = {22'd0, x} * {22'd0, DIV5_MUL};
    return p[43:24];
  endfunction

  // exp(-f), f in [0,1) as q32, alternating series, elaboration only
  function automatic longint unsigned exp_neg_frac(input longint unsigned f);
    longint signed   acc;
    longint unsigned term;
    acc  = 64'sh1_0000_0000;
    term = 64'h1_0000_0000;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * f) >> 32) / 64'(n);
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  // rom entry from its argument y (q32), rounded to q1.16
  function automatic logic [EXP_W-1:0] rom_value(input longint unsigned y);
    longint unsigned k;
    longint unsigned r;
    longint unsigned h;
    longint unsigned e1;
    k  = y >> 32;
    r  = exp_neg_frac(y & 64'hFFFF_FFFF);
    h  = exp_neg_frac(64'h8000_0000);
    e1 = (h * h + 64'h8000_0000) >> 32;
    for (longint unsigned j = 0; j < k; j++) begin
      r = (r * e1 + 64'h8000_0000) >> 32;
    end
    return EXP_W'((r + 64'd32768) >> 16);
  endfunction

endpackage
`default_nettype wire

/* sv/lse_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lse_front: operand intake
// takes one operand pair per transfer and registers the larger operand and
// the absolute difference for the queue
// ----------------------------------------------------------------------------
module lse_front import lse_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_valid,
  output logic                         s_ready,
  input  wire logic signed [VAL_W-1:0] value_a,
  input  wire logic signed [VAL_W-1:0] value_b,
  output lse_item_t                    item,
  output logic                         item_valid,
  input  wire logic                    item_ready
);

  logic [DIST_W-1:0] d_ab;
  logic [DIST_W-1:0] d_ba;
  logic              b_larger;

  // both differences side by side, the sign of a-b picks one
  assign d_ab     = {value_a[VAL_W-1], value_a} - {value_b[VAL_W-1], value_b};
  assign d_ba     = {value_b[VAL_W-1], value_b} - {value_a[VAL_W-1], value_a};
  assign b_larger = d_ab[DIST_W-1];

  assign s_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item.mx  <= b_larger ? value_b : value_a;
      item.gap <= b_larger ? d_ba : d_ab;
    end
  end

endmodule
`default_nettype wire

/* sv/lse_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lse_queue: item queue
// short first-in first-out buffer between the front end and the back end
// ----------------------------------------------------------------------------
module lse_queue import lse_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  wire lse_item_t wr_item,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output lse_item_t      rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lse_item_t      slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10: begin
          count <= count + 1'b1;
        end
        2'b01: begin
          count <= count - 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_empty: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("queue empty with pointers apart");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a write");
`endif

endmodule
`default_nettype wire

/* sv/lse_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lse_back: max-star arithmetic pipeline
// rom index and interpolation, log1p polynomial and saturating sum, all
// stages advancing together whenever the result register can move
// ----------------------------------------------------------------------------
module lse_back import lse_pkg::*; #(
  parameter int LUT_ENTRIES = LUT_ENTRIES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lse_item_t         item,
  input  wire logic              item_valid,
  output logic                   item_ready,
  output logic signed [VAL_W-1:0] log_sum,
  output logic                   saturated,
  output logic                   res_valid,
  input  wire logic              res_ready
);

  localparam int DW  = FRAC_BITS + 5;
  localparam int NW  = $clog2(LUT_ENTRIES);
  localparam int UW  = DW + NW;
  localparam int XW  = UW - FRAC_BITS - 2;
  localparam int PW  = EXP_W + DW;
  localparam int LFW = VAL_W - 2;
  localparam int NS  = 17;
  localparam int LutDiv = (LUT_ENTRIES > 1) ? LUT_ENTRIES - 1 : 1;
  localparam logic [DIST_W-1:0] DistLim = DIST_W'(20 * (2 ** FRAC_BITS));
  localparam logic [PW-1:0]     HalfD   = PW'(10 * (2 ** FRAC_BITS));
  localparam logic [NW-1:0]     TopIdx  = NW'(LUT_ENTRIES - 1);

  typedef struct packed {
    logic signed [VAL_W-1:0] mx;
    logic                    in_rng;
  } side_t;

  typedef struct packed {
    logic [15:0] e;
    logic        one;
    logic        mid;
    logic [30:0] shalf;
  } lp_t;

  // exp table over [-20,0]
  logic [EXP_W-1:0] rom_tbl [LUT_ENTRIES];
  for (genvar g = 0; g < LUT_ENTRIES; g++) begin : g_rom
    localparam longint unsigned RomArg =
      ((64'd20 * 64'(LUT_ENTRIES - 1 - g)) << 32) / 64'(LutDiv);
    localparam logic [EXP_W-1:0] RomVal = rom_value(RomArg);
    assign rom_tbl[g] = RomVal;
  end

  logic [NS-1:0] vld;
  logic          adv;
  side_t         side [NS-1];
  lp_t           lp [6];

  logic [DW-1:0]          t1;
  logic [UW-1:0]          u2;
  logic [XW-1:0]          x3;
  logic [NW-1:0]          qi3;
  logic [FRAC_BITS+1:0]   ulo3;
  logic [NW-1:0]          idx4;
  logic [DW-1:0]          rem4;
  logic [EXP_W-1:0]       r0_5;
  logic [EXP_W-1:0]       dif5;
  logic [DW-1:0]          rem5;
  logic [PW-1:0]          pr6;
  logic [EXP_W-1:0]       r0_6;
  logic [19:0]            qe7;
  logic [EXP_W-1:0]       r0_7;
  logic [EXP_W-1:0]       e8;
  logic [15:0]            e9;
  logic                   one9;
  logic                   mid9;
  logic [31:0]            s9;
  logic [47:0]            se10;
  logic [31:0]            c11;
  logic [63:0]            pm12;
  logic [31:0]            c12;
  logic [30:0]            q0_13;
  logic [51:0]            z13;
  logic [30:0]            q0_14;
  logic [51:0]            z14;
  logic [51:0]            qm14;
  logic [30:0]            q15;
  logic [17:0]            l16;

  logic                   in_rng;
  logic [XW-1:0]          five_q;
  logic [NW-1:0]          idx_nx;
  logic [51:0]            res14;
  logic [33:0]            p16;
  logic [LFW-1:0]         lf;
  logic signed [VAL_W:0]  sum_w;

  assign adv        = !vld[NS-1] || res_ready;
  assign item_ready = adv;
  assign res_valid  = vld[NS-1];

  assign in_rng = (item.gap <= DistLim);
  assign five_q = XW'(qi3) * XW'(5);
  assign idx_nx = (idx4 == TopIdx) ? idx4 : idx4 + 1'b1;
  assign res14  = z14 - qm14;

  // log1p polynomial: e - e^2/2, plus the cubic term in the middle range
  assign p16 = {2'b00, lp[5].e, 16'h0000} - 34'(lp[5].shalf)
             + (lp[5].mid ? 34'(q15) : 34'd0);

  // q16 correction to the operand fraction width
  if (FRAC_BITS < 16) begin : g_round
    localparam int Sh = 16 - FRAC_BITS;
    assign lf = LFW'((19'(l16) + (19'd1 << (Sh - 1))) >> Sh);
  end else if (FRAC_BITS > 16) begin : g_widen
    assign lf = LFW'(l16) << (FRAC_BITS - 16);
  end else begin : g_same
    assign lf = LFW'(l16);
  end

  assign sum_w = {side[NS-2].mx[VAL_W-1], side[NS-2].mx} + $signed((VAL_W + 1)'(lf));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{mx: item.mx, in_rng: in_rng};
      for (int k = 1; k < NS - 1; k++) begin
        side[k] <= side[k-1];
      end
      lp[0] <= '{e: e9, one: one9, mid: mid9, shalf: s9[31:1]};
      for (int k = 1; k < 6; k++) begin
        lp[k] <= lp[k-1];
      end

      // distance from the far end of the table, zero when out of range
      t1   <= in_rng ? DW'(DistLim - item.gap) : '0;
      u2   <= UW'(t1) * UW'(LUT_ENTRIES - 1);
      x3   <= u2[UW-1:FRAC_BITS+2];
      qi3  <= NW'(div5(22'(u2[UW-1:FRAC_BITS+2])));
      ulo3 <= u2[FRAC_BITS+1:0];
      idx4 <= qi3;
      rem4 <= {3'(x3 - five_q), ulo3};

      // interpolation between neighbouring entries
      r0_5 <= rom_tbl[idx4];
      dif5 <= rom_tbl[idx_nx] - rom_tbl[idx4];
      rem5 <= rem4;
      pr6  <= PW'(dif5) * PW'(rem5) + HalfD;
      r0_6 <= r0_5;
      qe7  <= div5(22'(pr6[PW-1:FRAC_BITS+2]));
      r0_7 <= r0_6;
      e8   <= r0_7 + EXP_W'(qe7);

      // log1p terms
      e9   <= e8[15:0];
      one9 <= e8[16];
      mid9 <= (e8[15:0] >= SMALL_E_LIMIT);
      s9   <= 32'(e8[15:0]) * 32'(e8[15:0]);
      se10 <= 48'(s9) * 48'(e9);
      c11  <= 32'((49'(se10) + 49'd32768) >> 16);
      pm12 <= 64'(c11) * THIRD_MUL;
      c12  <= c11;
      q0_13 <= 31'((pm12 + 64'h8000_0000) >> 32);
      z13   <= 52'(c12) * TERM_MUL + HALF_MILLION;
      q0_14 <= q0_13;
      z14   <= z13;
      qm14  <= 52'(q0_13) * MILLION;
      q15   <= (res14 >= MILLION) ? q0_14 + 1'b1 : q0_14;
      l16   <= lp[5].one ? 18'(LN2_Q16) : 18'((p16 + 34'd32768) >> 16);

      // saturating sum
      if (!side[NS-2].in_rng) begin
        log_sum   <= side[NS-2].mx;
        saturated <= 1'b0;
      end else if (sum_w > VAL_MAX) begin
        log_sum   <= VAL_MAX[VAL_W-1:0];
        saturated <= 1'b1;
      end else begin
        log_sum   <= sum_w[VAL_W-1:0];
        saturated <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    vld[NS-1] && saturated |-> log_sum == VAL_MAX[VAL_W-1:0])
    else $error("saturated result not at the top value");

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> e8 <= EXP_W'(65536))
    else $error("interpolated exp above one");

  a_quot_est: assert property (@(posedge clk) disable iff (rst)
    vld[13] |-> res14 < (MILLION + MILLION))
    else $error("cubic quotient estimate off by more than one");
`endif

endmodule
`default_nettype wire

/* sv/log_sum_exp_max_star.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// log_sum_exp_max_star: max-star (jacobian logarithm) unit
// returns max(a,b) + log1p(exp(-|a-b|)) on signed q11.12 operand pairs
// ----------------------------------------------------------------------------
// usage
//   input stream: one transfer carries an operand pair, value_a in the low
//   half of s_axis_tdata and value_b in the high half
//   output stream: one transfer per input transfer, in order, the result on
//   m_axis_tdata and the clip flag on m_axis_tuser
//   throughput: one pair per cycle while the output is not stalled; a
//   result passes the intake register, one queue slot and then the 17
//   back-end stages before it is presented on the output
//   back-end stages: rom interpolation, log1p polynomial, saturating add
//   differences above twenty pass the larger operand through untouched
//   reset: clears the intake register, the queue and every pipeline valid
//   flag; the exp table is constant logic and needs no loading
//   stall: while m_axis_tready is low and a result waits, the whole back
//   end holds; the queue keeps taking items until it is full, the intake
//   register holds one more, and only then does s_axis_tready fall
// ----------------------------------------------------------------------------
module log_sum_exp_max_star import lse_pkg::*; #(
  parameter int LUT_ENTRIES = LUT_ENTRIES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [2*VAL_W-1:0]   s_axis_tdata,   // value_a [23:0], value_b [47:24]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [VAL_W-1:0]          m_axis_tdata,   // log_sum [23:0]
  output logic                      m_axis_tuser    // saturated [0]
);

  lse_item_t               fr_item;
  logic                    fr_valid;
  logic                    fr_ready;
  lse_item_t               q_item;
  logic                    q_valid;
  logic                    q_ready;
  logic signed [VAL_W-1:0] log_sum;
  logic                    saturated;

  // intake: larger operand and distance
  lse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .value_a    ($signed(s_axis_tdata[VAL_W-1:0])),
    .value_b    ($signed(s_axis_tdata[2*VAL_W-1:VAL_W])),
    .item       (fr_item),
    .item_valid (fr_valid),
    .item_ready (fr_ready)
  );

  // decouples intake from the arithmetic pipeline
  lse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // correction term and saturating sum; its last stage is the output register
  lse_back #(
    .LUT_ENTRIES (LUT_ENTRIES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .log_sum    (log_sum),
    .saturated  (saturated),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready)
  );

  assign m_axis_tdata = log_sum;
  assign m_axis_tuser = saturated;

endmodule
`default_nettype wire
